// File: design/m4vt_pkg.sv
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared types, constants and the determinant term table for the 4x4 matrix
// vector transform unit.
// ----------------------------------------------------------------------------
package m4vt_pkg;

    localparam int DATA_W         = 32;
    localparam int ELEM_W         = 4;
    localparam int NUM_ELEMS      = 16;
    localparam int NUM_LANES      = 4;
    localparam int NUM_FACTORS    = 4;
    localparam int TERMS_PER_LANE = 6;
    localparam int NUM_TERMS      = NUM_LANES * TERMS_PER_LANE;
    localparam int FIX_FRAC       = 16;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int SHIFT_W        = PROD_W - FIX_FRAC;
    localparam int ACC_W          = SHIFT_W + 2;
    localparam int TERM_W         = $clog2(TERMS_PER_LANE);
    localparam int STEP_W         = $clog2(NUM_FACTORS);
    localparam int TIDX_W         = $clog2(NUM_TERMS);
    localparam int CNT_W          = TERM_W + STEP_W + 1;
    localparam int XFORM_END      = NUM_FACTORS;
    localparam int DET_END        = TERMS_PER_LANE * NUM_FACTORS * 2;

    localparam logic signed [DATA_W-1:0] FIX_ONE = DATA_W'(32'sh0001_0000);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_XFORM = 2'd1;
    localparam logic [1:0] OP_DET   = 2'd2;

    localparam logic KIND_XFORM = 1'b0;
    localparam logic KIND_DET   = 1'b1;

    // {negate, f3, f2, f1, f0}; factors are multiplied in order f0..f3
    localparam logic [16:0] DET_TERMS [NUM_TERMS] = '{
        {1'b0, 16'h369C}, {1'b1, 16'h36D8}, {1'b1, 16'h3A5C},
        {1'b0, 16'h3AD4}, {1'b0, 16'h3E58}, {1'b1, 16'h3E94},
        {1'b1, 16'h729C}, {1'b0, 16'h72D8}, {1'b0, 16'h7A1C},
        {1'b1, 16'h7AD0}, {1'b1, 16'h7E18}, {1'b0, 16'h7E90},
        {1'b0, 16'hB25C}, {1'b1, 16'hB2D4}, {1'b1, 16'hB61C},
        {1'b0, 16'hB6D0}, {1'b0, 16'hBE14}, {1'b1, 16'hBE50},
        {1'b1, 16'hF258}, {1'b0, 16'hF294}, {1'b0, 16'hF618},
        {1'b1, 16'hF690}, {1'b1, 16'hFA14}, {1'b0, 16'hFA50}
    };

    typedef struct packed {
        logic [1:0]               opcode;
        logic [ELEM_W-1:0]        elem_index;
        logic signed [DATA_W-1:0] elem_value;
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
        logic signed [DATA_W-1:0] vec_w;
    } t_in_req;

    typedef struct packed {
        logic                     result_kind;
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic signed [DATA_W-1:0] out_w;
        logic signed [DATA_W-1:0] det_value;
    } t_out_res;

    typedef struct packed {
        logic                     wr;
        logic [ELEM_W-1:0]        wr_addr;
        logic signed [DATA_W-1:0] wr_data;
        logic                     clr;
        logic                     mul;
        logic                     xform;
        logic                     src_p;
        logic [TERM_W-1:0]        term;
        logic [STEP_W-1:0]        step;
        logic                     last;
    } t_lane_ctl;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[ACC_W-1:DATA_W-1];
        all_zero = ~|v[ACC_W-1:DATA_W-1];
        if (all_one || all_zero) begin
            sat32 = v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            sat32 = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat32 = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

// File: design/m4vt_lane.sv
// ----------------------------------------------------------------------------
// m4vt_lane
// One arithmetic lane: private copy of the matrix, a 32x32 multiplier,
// Q16.16 rescale, and an accumulator for a row dot product or for six
// determinant terms.
// ----------------------------------------------------------------------------
module m4vt_lane #(
    parameter int LANE = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  m4vt_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [m4vt_pkg::DATA_W-1:0]    i_opa,
    output logic signed [m4vt_pkg::ACC_W-1:0]     o_acc
);
    import m4vt_pkg::*;

    localparam int TERM_BASE = LANE * TERMS_PER_LANE;

    logic signed [DATA_W-1:0]  r_mat [NUM_ELEMS];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DATA_W-1:0]  r_p;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_s2_valid;
    logic                      r_s2_xform;
    logic                      r_s2_last;
    logic                      r_s2_neg;
    logic                      r_fin;
    logic                      r_fin_neg;

    logic [TIDX_W-1:0]         w_tidx;
    logic [16:0]               w_entry;
    logic [ELEM_W-1:0]         w_addr;
    logic signed [DATA_W-1:0]  w_opa;
    logic signed [DATA_W-1:0]  w_opb;
    logic signed [SHIFT_W-1:0] w_shift;
    logic signed [ACC_W-1:0]   w_shift_ext;
    logic signed [ACC_W-1:0]   w_p_ext;

    assign w_tidx  = TIDX_W'(TERM_BASE) + TIDX_W'(i_ctl.term);
    assign w_entry = DET_TERMS[w_tidx];
    assign w_addr  = i_ctl.xform ? {i_ctl.step, 2'(LANE)}
                                 : w_entry[{i_ctl.step, 2'b00} +: ELEM_W];
    assign w_opa   = i_ctl.src_p ? r_p : i_opa;
    assign w_opb   = r_mat[w_addr];

    assign w_shift     = r_prod[PROD_W-1:FIX_FRAC];
    assign w_shift_ext = {{(ACC_W-SHIFT_W){w_shift[SHIFT_W-1]}}, w_shift};
    assign w_p_ext     = {{(ACC_W-DATA_W){r_p[DATA_W-1]}}, r_p};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ELEMS; i++) begin
                r_mat[i] <= (i[1:0] == i[3:2]) ? FIX_ONE : '0;
            end
        end else if (i_ctl.wr) begin
            r_mat[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= w_opa * w_opb;
        end
        if (r_s2_valid && !r_s2_xform) begin
            r_p <= sat32(w_shift_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s2_xform <= 1'b0;
            r_s2_last  <= 1'b0;
            r_s2_neg   <= 1'b0;
            r_fin      <= 1'b0;
            r_fin_neg  <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_s2_valid <= i_ctl.mul;
            r_s2_xform <= i_ctl.xform;
            r_s2_last  <= i_ctl.last;
            r_s2_neg   <= w_entry[16];
            r_fin      <= r_s2_valid && !r_s2_xform && r_s2_last;
            r_fin_neg  <= r_s2_neg;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end else if (r_s2_valid && r_s2_xform) begin
                r_acc <= r_acc + w_shift_ext;
            end else if (r_fin) begin
                r_acc <= r_fin_neg ? r_acc - w_p_ext : r_acc + w_p_ext;
            end
        end
    end

    assign o_acc = r_acc;

    // chained multiply must see the product of the previous factor
    a_p_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.mul && i_ctl.src_p) |-> !r_s2_valid)
        else $error("lane %0d: chained multiply issued before rescale", LANE);

    a_fin_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> !(r_s2_valid && r_s2_xform))
        else $error("lane %0d: term add collides with transform add", LANE);

    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clr |-> !r_s2_valid && !r_fin)
        else $error("lane %0d: clear while work in flight", LANE);

endmodule

// File: design/m4vt_merge.sv
// ----------------------------------------------------------------------------
// m4vt_merge
// Combines the lane accumulators into one result (per-lane saturation for a
// transform, summed and saturated for a determinant) and holds it in the
// output register.
// ----------------------------------------------------------------------------
module m4vt_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [m4vt_pkg::ACC_W-1:0]   i_acc [m4vt_pkg::NUM_LANES],
    input  logic                                i_kind,
    input  logic                                i_load,
    input  logic                                i_out_stall,
    output logic                                o_free,
    output logic                                o_out_valid,
    output m4vt_pkg::t_out_res                  o_out_res
);
    import m4vt_pkg::*;

    logic                    r_valid;
    t_out_res                r_res;
    logic signed [ACC_W-1:0] w_sum;
    t_out_res                w_res;

    assign w_sum = (i_acc[0] + i_acc[1]) + (i_acc[2] + i_acc[3]);

    always_comb begin
        w_res             = '0;
        w_res.result_kind = i_kind;
        if (i_kind == KIND_XFORM) begin
            w_res.out_x = sat32(i_acc[0]);
            w_res.out_y = sat32(i_acc[1]);
            w_res.out_z = sat32(i_acc[2]);
            w_res.out_w = sat32(i_acc[3]);
        end else begin
            w_res.det_value = sat32(w_sum);
        end
    end

    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_res   = r_res;

endmodule

// File: design/matrix4_vector_transform_unit.sv
// ----------------------------------------------------------------------------
// matrix4_vector_transform_unit
// 4x4 Q16.16 homogeneous matrix with element write, vector transform and
// determinant.
// ----------------------------------------------------------------------------
// Four lanes, one per matrix row, each with its own 32x32 multiplier and a
// copy of the matrix. A write is taken without stalling the input and gives
// no result. A transform feeds one vector component per cycle to all lanes.
// A determinant runs six terms per lane, each a chain of four dependent
// multiply and rescale steps. For either, the input stalls until the result
// is loaded into the output register, so no new request is taken while one
// is in flight. A finished result waits in the output register while the
// next request is taken.
// ----------------------------------------------------------------------------
module matrix4_vector_transform_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  m4vt_pkg::t_in_req     i_in_req,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output m4vt_pkg::t_out_res    o_out_res,
    input  logic                  i_out_stall
);
    import m4vt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_MERGE
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_kind;
    logic signed [DATA_W-1:0] r_vec [NUM_FACTORS];

    logic                     w_in_acc;
    logic                     w_is_calc;
    logic [CNT_W-1:0]         w_end;
    logic                     w_out_free;
    logic                     w_load;
    t_lane_ctl                w_ctl;
    logic signed [DATA_W-1:0] w_opa;
    logic signed [ACC_W-1:0]  w_acc [NUM_LANES];

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_is_calc  = (i_in_req.opcode == OP_XFORM) || (i_in_req.opcode == OP_DET);
    assign w_end      = (r_kind == KIND_XFORM) ? CNT_W'(XFORM_END) : CNT_W'(DET_END);
    assign w_load     = (r_state == S_MERGE) && w_out_free;

    always_comb begin
        w_ctl         = '0;
        w_opa         = FIX_ONE;
        w_ctl.wr      = w_in_acc && (i_in_req.opcode == OP_WRITE);
        w_ctl.wr_addr = i_in_req.elem_index;
        w_ctl.wr_data = i_in_req.elem_value;
        w_ctl.clr     = w_in_acc && w_is_calc;
        if (r_state == S_RUN) begin
            if (r_kind == KIND_XFORM) begin
                w_ctl.xform = 1'b1;
                w_ctl.step  = r_cnt[STEP_W-1:0];
                w_ctl.mul   = r_cnt < CNT_W'(XFORM_END);
                w_opa       = r_vec[r_cnt[STEP_W-1:0]];
            end else begin
                w_ctl.mul   = (r_cnt < CNT_W'(DET_END)) && !r_cnt[0];
                w_ctl.term  = r_cnt[CNT_W-1 -: TERM_W];
                w_ctl.step  = r_cnt[STEP_W:1];
                w_ctl.src_p = r_cnt[STEP_W:1] != '0;
                w_ctl.last  = r_cnt[STEP_W:1] == STEP_W'(NUM_FACTORS - 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_is_calc) begin
            r_vec[0] <= i_in_req.vec_x;
            r_vec[1] <= i_in_req.vec_y;
            r_vec[2] <= i_in_req.vec_z;
            r_vec[3] <= i_in_req.vec_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_kind  <= KIND_XFORM;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (w_in_acc && w_is_calc) begin
                        r_kind  <= (i_in_req.opcode == OP_DET) ? KIND_DET : KIND_XFORM;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == w_end) begin
                        r_state <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        m4vt_lane #(
            .LANE (g)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_opa   (w_opa),
            .o_acc   (w_acc[g])
        );
    end

    m4vt_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_acc),
        .i_kind      (r_kind),
        .i_load      (w_load),
        .i_out_stall (i_out_stall),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

    a_calc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_calc) |=> o_in_stall)
        else $error("calc request did not start the sequencer");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_is_calc && !o_out_valid) |=> !o_out_valid)
        else $error("write or unused opcode produced a result");

    a_merge_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_out_valid && !o_in_stall)
        else $error("merged result not presented");

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4x4 Q16.16 matrix vector transform unit. Runs a
// table of directed requests, then random writes, transforms and determinants
// under three sender/receiver stall mixes. Each result is checked against its
// typed table value or a local matrix copy and bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import m4vt_pkg::*;

    localparam logic [1:0] OP_NONE         = 2'd3;
    localparam int         ITEMS_PER_PHASE = 500;
    localparam int         DRAIN_CYCLES    = 60;
    localparam longint     Q_MAX           = 64'sd2147483647;
    localparam longint     Q_MIN           = -64'sd2147483648;

    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_res res;
    } t_dir_row;

    logic     clk       = 1'b0;
    logic     rst_n;
    logic     in_valid;
    t_in_req  in_req;
    logic     in_stall;
    logic     out_valid;
    t_out_res out_res;
    logic     out_stall = 1'b0;

    int unsigned snd_idle_pct = 14;
    int unsigned rcv_idle_pct = 78;
    int          n_fail       = 0;

    logic signed [DATA_W-1:0] shadow_mat [NUM_ELEMS];
    t_out_res                 awaited_outputs [$];

    // Laplace expansion terms: factor indices in multiply order, and sign
    int det_fac [NUM_TERMS][NUM_FACTORS] = '{
        '{12, 9, 6, 3},  '{8, 13, 6, 3},  '{12, 5, 10, 3},
        '{4, 13, 10, 3}, '{8, 5, 14, 3},  '{4, 9, 14, 3},
        '{12, 9, 2, 7},  '{8, 13, 2, 7},  '{12, 1, 10, 7},
        '{0, 13, 10, 7}, '{8, 1, 14, 7},  '{0, 9, 14, 7},
        '{12, 5, 2, 11}, '{4, 13, 2, 11}, '{12, 1, 6, 11},
        '{0, 13, 6, 11}, '{4, 1, 14, 11}, '{0, 5, 14, 11},
        '{8, 5, 2, 15},  '{4, 9, 2, 15},  '{8, 1, 6, 15},
        '{0, 9, 6, 15},  '{4, 1, 10, 15}, '{0, 5, 10, 15}
    };
    bit det_neg [NUM_TERMS] = '{
        0, 1, 1, 0, 0, 1,  1, 0, 0, 1, 1, 0,
        0, 1, 1, 0, 0, 1,  1, 0, 0, 1, 1, 0
    };

    t_dir_row dir_rows [24] = '{
        '{'{OP_DET, 4'hA, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
          '{KIND_DET, 32'h0, 32'h0, 32'h0, 32'h0, FIX_ONE}},
        '{'{OP_XFORM, 4'h5, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
            32'h7FFF_FFFF, 32'h8000_0000}, 1'b1,
          '{KIND_XFORM, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h0}},
        '{'{OP_NONE, 4'hF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{OP_DET, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
            32'h0}, 1'b1, '{KIND_DET, 32'h0, 32'h0, 32'h0, 32'h0, FIX_ONE}},
        '{'{OP_WRITE, 4'h0, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
            32'hFFFF_FFFF, 32'h8000_0000}, 1'b0, '0},
        '{'{OP_WRITE, 4'h1, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0,
            32'h1}, 1'b0, '0},
        '{'{OP_WRITE, 4'h2, 32'h0000_0000, 32'h1, 32'h2, 32'h3, 32'h4}, 1'b0, '0},
        '{'{OP_WRITE, 4'h3, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 4'h4, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 4'h5, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 4'h6, 32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 4'h7, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 4'h8, 32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 4'h9, 32'hFFFE_0000, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 4'hA, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 4'hB, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 4'hC, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 4'hD, 32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 4'hE, 32'h0001_8000, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_WRITE, 4'hF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_XFORM, 4'h3, 32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF}, 1'b0, '0},
        '{'{OP_XFORM, 4'hC, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000}, 1'b0, '0},
        '{'{OP_DET, 4'h7, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{OP_XFORM, 4'h0, 32'h0, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000,
            32'h0001_0000}, 1'b0, '0}
    };

    matrix4_vector_transform_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_req    (in_req),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_res   (out_res),
        .i_out_stall (out_stall)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint q16_mul(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return prod >>> FIX_FRAC;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_q16(input longint v);
        if (v > Q_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (v < Q_MIN) begin
            return 32'sh8000_0000;
        end
        return DATA_W'(v);
    endfunction

    // updates the shadow matrix; returns 1 when the request yields a result
    function automatic bit apply_matrix_op(input t_in_req r, output t_out_res res);
        logic signed [DATA_W-1:0] vec  [NUM_LANES];
        logic signed [DATA_W-1:0] lane [NUM_LANES];
        logic signed [DATA_W-1:0] p;
        longint                   acc;
        res = '0;
        case (r.opcode)
            OP_WRITE: begin
                shadow_mat[r.elem_index] = r.elem_value;
                return 1'b0;
            end
            OP_XFORM: begin
                vec[0] = r.vec_x;
                vec[1] = r.vec_y;
                vec[2] = r.vec_z;
                vec[3] = r.vec_w;
                for (int row = 0; row < NUM_LANES; row++) begin
                    acc = 0;
                    for (int k = 0; k < NUM_LANES; k++) begin
                        acc += q16_mul(shadow_mat[row + 4 * k], vec[k]);
                    end
                    lane[row] = clamp_q16(acc);
                end
                res.result_kind = KIND_XFORM;
                res.out_x       = lane[0];
                res.out_y       = lane[1];
                res.out_z       = lane[2];
                res.out_w       = lane[3];
                return 1'b1;
            end
            OP_DET: begin
                acc = 0;
                for (int t = 0; t < NUM_TERMS; t++) begin
                    p = clamp_q16(q16_mul(shadow_mat[det_fac[t][0]],
                                          shadow_mat[det_fac[t][1]]));
                    p = clamp_q16(q16_mul(p, shadow_mat[det_fac[t][2]]));
                    p = clamp_q16(q16_mul(p, shadow_mat[det_fac[t][3]]));
                    acc += det_neg[t] ? -longint'(p) : longint'(p);
                end
                res.result_kind = KIND_DET;
                res.det_value   = clamp_q16(acc);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_q16();
        case ($urandom_range(9))
            0:          return 32'sh7FFF_FFFF;
            1:          return 32'sh8000_0000;
            2:          return '0;
            3:          return ($urandom_range(1) != 0) ? FIX_ONE : -FIX_ONE;
            4, 5, 6, 7: return DATA_W'($signed($urandom_range(524288)) - 262144);
            default:    return $urandom;
        endcase
    endfunction

    function automatic t_in_req rand_req();
        t_in_req     r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            r.opcode = OP_WRITE;
        end else if (pick < 85) begin
            r.opcode = OP_XFORM;
        end else if (pick < 95) begin
            r.opcode = OP_DET;
        end else begin
            r.opcode = OP_NONE;
        end
        r.elem_index = ELEM_W'($urandom_range(NUM_ELEMS - 1));
        r.elem_value = rand_q16();
        r.vec_x      = rand_q16();
        r.vec_y      = rand_q16();
        r.vec_z      = rand_q16();
        r.vec_w      = rand_q16();
        return r;
    endfunction

    task automatic send_req(input t_in_req r, input bit typed, input t_out_res typed_res);
        t_out_res pred;
        bit       has_res;
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (in_stall);
        has_res = apply_matrix_op(r, pred);
        if (has_res) begin
            awaited_outputs.insert(awaited_outputs.size(), typed ? typed_res : pred);
        end
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_outputs.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic signed [DATA_W-1:0] exp_v,
                               input logic signed [DATA_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            n_fail++;
        end
    endtask

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    always @(posedge clk) begin
        t_out_res exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (awaited_outputs.size() == 0) begin
                $error("unexpected result: kind %0d det %0d", out_res.result_kind,
                       out_res.det_value);
                n_fail++;
            end else begin
                exp_r = awaited_outputs.pop_front();
                check_field("result_kind", DATA_W'(exp_r.result_kind),
                            DATA_W'(out_res.result_kind));
                check_field("out_x", exp_r.out_x, out_res.out_x);
                check_field("out_y", exp_r.out_y, out_res.out_y);
                check_field("out_z", exp_r.out_z, out_res.out_z);
                check_field("out_w", exp_r.out_w, out_res.out_w);
                check_field("det_value", exp_r.det_value, out_res.det_value);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_in_req r;
        int      n_items;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_req   = '0;
        for (int i = 0; i < NUM_ELEMS; i++) begin
            shadow_mat[i] = (i % 5 == 0) ? FIX_ONE : '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        end
        wait_results_drained();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 14;
                    rcv_idle_pct = 78;
                end
                1: begin
                    snd_idle_pct = 78;
                    rcv_idle_pct = 14;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            n_items = 0;
            while (n_items < ITEMS_PER_PHASE) begin
                r = rand_req();
                send_req(r, 1'b0, '0);
                if (r.opcode != OP_NONE) begin
                    n_items++;
                end
            end
            // hold off new requests until every result is back
            wait_results_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_fail == 0 && awaited_outputs.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
